// File: rtl/sos_pkg.sv
package sos_pkg;

    // Number of switch outputs held by the block.
    localparam int CHANNELS = 4;

    // Width of a channel index inside the block.
    localparam int POS_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // Channels that appear in the packed level word and in the scan pattern.
    localparam int PACK_W = 4;

    localparam int CMD_W     = 3;
    localparam int CHAN_W    = 3;
    localparam int DELAY_W   = 16;
    localparam int PATTERN_W = 4;
    localparam int OUT_CH_W  = 2;

    localparam logic [DELAY_W-1:0] DELAY_RESET = DELAY_W'(10);

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_SET    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_TOGGLE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_START  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_TICK   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_STEP   = 3'd4;

    typedef struct packed {
        logic [CMD_W-1:0]     cmd;
        logic [CHAN_W-1:0]    channel;
        logic                 on_request;
        logic [DELAY_W-1:0]   scan_delay;
        logic [PATTERN_W-1:0] scan_pattern;
    } req_t;

    typedef struct packed {
        logic                 hit;
        logic [OUT_CH_W-1:0]  out_channel;
        logic                 out_level;
        logic [PACK_W-1:0]    all_levels;
    } res_t;

endpackage

// File: rtl/sos_core.sv
module sos_core
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          fire,
    input  sos_pkg::req_t req,
    output sos_pkg::res_t res
);

    logic [sos_pkg::CHANNELS-1:0]  levels_reg;
    logic [sos_pkg::CHANNELS-1:0]  levels_next;
    logic [sos_pkg::DELAY_W-1:0]   step_delay_reg;
    logic [sos_pkg::DELAY_W-1:0]   step_delay_next;
    logic                          scan_active_reg;
    logic                          scan_active_next;
    logic [sos_pkg::DELAY_W-1:0]   tick_count_reg;
    logic [sos_pkg::DELAY_W-1:0]   tick_count_next;
    logic [sos_pkg::PATTERN_W-1:0] pattern_reg;
    logic [sos_pkg::PATTERN_W-1:0] pattern_next;
    logic [sos_pkg::POS_W-1:0]     scan_position_reg;
    logic [sos_pkg::POS_W-1:0]     scan_position_next;

    logic                          chan_ok;
    logic [sos_pkg::POS_W-1:0]     chan_idx;
    logic [sos_pkg::POS_W-1:0]     pos;
    logic                          pat_bit;
    logic [sos_pkg::POS_W-1:0]     emit_idx;

    always_comb
    begin
        chan_ok  = (int'(req.channel) < sos_pkg::CHANNELS);
        chan_idx = sos_pkg::POS_W'(req.channel);

        // Wrap a stale position back to the first channel.
        pos = (int'(scan_position_reg) < sos_pkg::CHANNELS) ? scan_position_reg : '0;
        pat_bit = (int'(pos) < sos_pkg::PACK_W) ?
                  pattern_reg[2'(pos)] : 1'b0;

        levels_next        = levels_reg;
        step_delay_next    = step_delay_reg;
        scan_active_next   = scan_active_reg;
        tick_count_next    = tick_count_reg;
        pattern_next       = pattern_reg;
        scan_position_next = scan_position_reg;
        emit_idx           = chan_idx;
        res.hit            = 1'b0;

        case (req.cmd)
            sos_pkg::CMD_SET:
            begin
                if (chan_ok)
                begin
                    levels_next[chan_idx] = req.on_request;
                    res.hit = 1'b1;
                end
            end
            sos_pkg::CMD_TOGGLE:
            begin
                if (chan_ok)
                begin
                    levels_next[chan_idx] = ~levels_reg[chan_idx];
                    res.hit = 1'b1;
                end
            end
            sos_pkg::CMD_START:
            begin
                step_delay_next  = req.scan_delay;
                pattern_next     = req.scan_pattern;
                scan_active_next = 1'b1;
                tick_count_next  = '0;
            end
            sos_pkg::CMD_TICK:
            begin
                if (scan_active_reg)
                begin
                    tick_count_next = tick_count_reg + 1'b1;
                end
            end
            sos_pkg::CMD_STEP:
            begin
                if (scan_active_reg && (tick_count_reg > step_delay_reg))
                begin
                    levels_next[pos] = pat_bit;
                    emit_idx         = pos;
                    res.hit          = 1'b1;
                    tick_count_next  = '0;
                    if (int'(pos) == sos_pkg::CHANNELS - 1)
                    begin
                        scan_active_next   = 1'b0;
                        scan_position_next = '0;
                    end
                    else
                    begin
                        scan_position_next = pos + 1'b1;
                    end
                end
            end
            default:
            begin
                res.hit = 1'b0;
            end
        endcase

        res.out_channel = sos_pkg::OUT_CH_W'(emit_idx);
        res.out_level   = levels_next[emit_idx];
        res.all_levels  = '0;
        for (int k = 0; k < sos_pkg::PACK_W; k++)
        begin
            if (k < sos_pkg::CHANNELS)
            begin
                res.all_levels[k] = levels_next[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            levels_reg        <= '0;
            step_delay_reg    <= sos_pkg::DELAY_RESET;
            scan_active_reg   <= 1'b0;
            tick_count_reg    <= '0;
            pattern_reg       <= '0;
            scan_position_reg <= '0;
        end
        else if (fire)
        begin
            levels_reg        <= levels_next;
            step_delay_reg    <= step_delay_next;
            scan_active_reg   <= scan_active_next;
            tick_count_reg    <= tick_count_next;
            pattern_reg       <= pattern_next;
            scan_position_reg <= scan_position_next;
        end
    end

endmodule

// File: rtl/staggered_output_switch_sequencer.sv
// Staggered output switch sequencer.
//
// Input channel (in_valid / in_ready): one command request per handshake,
// with cmd, channel, on_request, scan_delay and scan_pattern as payload.
// Set and toggle drive one of four switch outputs; start scan loads a delay
// and a level pattern; tick advances the scan timer; scan step drives the
// next channel from the pattern once the timer has passed the delay.
// Output channel (out_valid / out_ready): zero or one result request per
// command, carrying out_channel, out_level and all_levels.
//
// An accepted command goes from the input register through the state-update
// stage into the result register. Throughput: one command per cycle while the
// receiver takes results, set by the single state-update stage between the
// input and result registers. Commands with no result (start, tick, unknown
// codes, out-of-range channels, steps not yet due) still pass the update stage.
//
// Reset: all outputs off, delay 10, no scan armed, timer and scan position
// at zero; both pipeline registers empty.
// Receiver stall: a held result keeps its payload; the input register holds
// its command for the update stage, and in_ready stays low while it is full.
module staggered_output_switch_sequencer
(
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [sos_pkg::CMD_W-1:0]       cmd,
    input  logic [sos_pkg::CHAN_W-1:0]      channel,
    input  logic                            on_request,
    input  logic [sos_pkg::DELAY_W-1:0]     scan_delay,
    input  logic [sos_pkg::PATTERN_W-1:0]   scan_pattern,

    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [sos_pkg::OUT_CH_W-1:0]    out_channel,
    output logic                            out_level,
    output logic [sos_pkg::PACK_W-1:0]      all_levels
);

    // Input register: holds the accepted command request.
    logic          in_valid_reg;
    sos_pkg::req_t req_reg;

    // Result register.
    logic          out_valid_reg;
    sos_pkg::res_t res_reg;

    sos_pkg::res_t res;
    logic          advance;

    // Advance the held command once the result register can take its result.
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    sos_core u_core
    (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (advance),
        .req   (req_reg),
        .res   (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            req_reg.cmd          <= cmd;
            req_reg.channel      <= channel;
            req_reg.on_request   <= on_request;
            req_reg.scan_delay   <= scan_delay;
            req_reg.scan_pattern <= scan_pattern;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= res.hit;
        end
        else if (out_ready)
        begin
            // Drop the result once the receiver has taken it.
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res.hit)
        begin
            res_reg <= res;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_channel = res_reg.out_channel;
    assign out_level   = res_reg.out_level;
    assign all_levels  = res_reg.all_levels;

endmodule
